// ===== src/crs_pkg.sv =====
// Shared types and constants of the Catmull-Rom image sampler.
package crs_pkg;

    localparam int ACC_W     = 32;
    localparam int PIX_W     = 16;
    localparam int COORD_W   = 20;
    localparam int OUT_W     = 24;
    localparam int SIZE_W    = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic OPC_WRITE  = 1'b0;
    localparam logic OPC_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef acc_t acc_quad_t [4];
    typedef logic signed [OUT_W-1:0] out_t;

    localparam acc_t OUT_MAX = 32'sd8388607;
    localparam acc_t OUT_MIN = -32'sd8388608;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

    function automatic out_t sat_out(input acc_t v);
        out_t r;
        if (v > OUT_MAX)
        begin
            r = OUT_MAX[OUT_W-1:0];
        end
        else if (v < OUT_MIN)
        begin
            r = OUT_MIN[OUT_W-1:0];
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/crs_if.sv =====
// Request and result channel interfaces of the sampler.
interface crs_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  opcode;
    logic [7:0]  write_col;
    logic [7:0]  write_row;
    logic [15:0] write_value;
    logic signed [19:0] sample_x;
    logic signed [19:0] sample_y;

    modport source (output valid, output opcode, output write_col, output write_row,
                    output write_value, output sample_x, output sample_y, input ready);
    modport sink (input valid, input opcode, input write_col, input write_row,
                  input write_value, input sample_x, input sample_y, output ready);
endinterface

interface crs_out_if;
    logic        valid;
    logic        ready;
    logic signed [23:0] sample_value;
    logic signed [23:0] grad_x;
    logic signed [23:0] grad_y;

    modport source (output valid, output sample_value, output grad_x, output grad_y,
                    input ready);
    modport sink (input valid, input sample_value, input grad_x, input grad_y,
                  output ready);
endinterface

// ===== src/crs_pixel_mem.sv =====
// Four replicated pixel memories, one read port each, common write port.
module crs_pixel_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                  clk,
    input  crs_pkg::mem_ctrl_t    ctrl,
    input  logic [AW-1:0]         waddr,
    input  logic [15:0]           wdata,
    input  logic [AW-1:0]         raddr [4],
    output logic [15:0]           rdata [4]
);
    import crs_pkg::*;

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        logic [15:0] bank [DEPTH];
        logic [15:0] rd_q;

        always_ff @(posedge clk)
        begin
            if (ctrl.wr_en)
            begin
                bank[waddr] <= wdata;
            end
            if (ctrl.rd_en)
            begin
                rd_q <= bank[raddr[g]];
            end
        end

        assign rdata[g] = rd_q;
    end

endmodule

// ===== src/crs_cubic.sv =====
// Iterative Catmull-Rom cubic unit: value and derivative by Horner steps.
module crs_cubic #(
    parameter int FRAC = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [FRAC-1:0]     t,
    input  crs_pkg::acc_quad_t  p,
    output crs_pkg::acc_t       value,
    output crs_pkg::acc_t       deriv,
    output logic                done
);
    import crs_pkg::*;

    localparam int PW = ACC_W + FRAC + 1;
    localparam logic signed [PW-1:0] HALF = PW'(64'(1) << (FRAC - 1));

    acc_t c0_reg, c1_reg, c2_reg;
    acc_t a_reg, b_reg;
    logic [1:0] step_reg, step_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    acc_t c0, c1, c2, c3;
    logic signed [PW-1:0] t_s, prod_a, prod_b, sum_a, sum_b;
    acc_t ra, rb;

    assign c0 = 2 * p[1];
    assign c1 = p[2] - p[0];
    assign c2 = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
    assign c3 = -p[0] + 3 * p[1] - 3 * p[2] + p[3];

    assign t_s    = PW'($signed({1'b0, t}));
    assign prod_a = PW'(a_reg) * t_s;
    assign prod_b = PW'(b_reg) * t_s;
    assign sum_a  = (prod_a + HALF) >>> FRAC;
    assign sum_b  = (prod_b + HALF) >>> FRAC;
    assign ra     = sum_a[ACC_W-1:0];
    assign rb     = sum_b[ACC_W-1:0];

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            step_next = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            c0_reg <= c0;
            c1_reg <= c1;
            c2_reg <= c2;
            a_reg  <= c3;
            b_reg  <= 3 * c3;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                2'd0:
                begin
                    a_reg <= c2_reg + ra;
                    b_reg <= 2 * c2_reg + rb;
                end
                2'd1:
                begin
                    a_reg <= c1_reg + ra;
                    b_reg <= c1_reg + rb;
                end
                default:
                begin
                    a_reg <= c0_reg + ra;
                end
            endcase
        end
    end

    assign value = (a_reg + 32'sd1) >>> 1;
    assign deriv = (b_reg + 32'sd1) >>> 1;
    assign done  = done_reg;

endmodule

// ===== src/catmull_rom_image_sampler_core.sv =====
// Top level of the Catmull-Rom bicubic image sampler.
// Usage:
//   request carries words with opcode write or sample. A write word stores one
//   pixel and is taken once per cycle while no sample is in flight; writes
//   outside the store are dropped. A sample word holds x and y in fixed point;
//   the block clamps the 4x4 neighbourhood and returns value, x gradient and y
//   gradient on result. For each of the four rows the four replicated pixel
//   memories are read together, then the shared cubic unit interpolates along
//   x; two passes along y follow, one over the row values and one over the
//   row derivatives. No new word is taken until the result register is loaded.
//   cfg_we writes the column count (index 0) or the row count (index 1); the
//   user must write them only while idle, as the block does not enforce it.
//   Reset sets both sizes to 256; pixel contents stay undefined until written.
//   A stalled result holds in the output register; a finished sample waits
//   there until result.ready, while new writes keep being taken meanwhile.
module catmull_rom_image_sampler_core #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [crs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [crs_pkg::SIZE_W-1:0]      cfg_wdata,
    crs_in_if.sink                          request,
    crs_out_if.source                       result
);
    import crs_pkg::*;

    localparam int F     = COORD_FRAC_BITS;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DIM_W = 13;
    localparam int KW0   = COORD_W - F + 2;
    localparam int KW    = (KW0 > DIM_W + 1) ? KW0 : DIM_W + 1;

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_READ       = 9'b000000010,
        S_START      = 9'b000000100,
        S_CALC       = 9'b000001000,
        S_Y_VAL      = 9'b000010000,
        S_Y_VAL_WAIT = 9'b000100000,
        S_Y_DER      = 9'b001000000,
        S_Y_DER_WAIT = 9'b010000000,
        S_OUT        = 9'b100000000
    } state_t;

    function automatic logic [DIM_W-1:0] clamp_idx(input logic signed [COORD_W-1:0] c,
                                                   input logic [1:0] i,
                                                   input logic [DIM_W-1:0] size);
        logic signed [KW-1:0] k;
        logic signed [KW-1:0] hi;
        logic [DIM_W-1:0] r;
        k  = KW'(c >>> F) + KW'($signed({1'b0, i})) - KW'(1);
        hi = KW'($signed({1'b0, size})) - KW'(1);
        if (k < 0)
        begin
            r = '0;
        end
        else if (k > hi)
        begin
            r = size - DIM_W'(1);
        end
        else
        begin
            r = k[DIM_W-1:0];
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0] width_reg, height_reg;

    logic [XW-1:0] xs_reg [4];
    logic [YW-1:0] ys_reg [4];
    logic [F-1:0]  tx_reg, ty_reg;
    acc_t rv_reg [4];
    acc_t rd_reg [4];
    acc_t val_reg, gy_reg, gx_reg;
    out_t out_val_reg, out_gx_reg, out_gy_reg;

    logic [DIM_W-1:0] eff_w, eff_h;
    logic accept, can_load;
    mem_ctrl_t mem_ctrl;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr [4];
    logic [15:0]   rdata [4];

    logic cub_start, cub_done;
    logic [F-1:0] cub_t;
    acc_quad_t cub_p;
    acc_t cub_value, cub_deriv;

    assign eff_w = (width_reg == '0) ? DIM_W'(1) :
                   ((DIM_W'(width_reg) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                            : DIM_W'(width_reg));
    assign eff_h = (height_reg == '0) ? DIM_W'(1) :
                   ((DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                              : DIM_W'(height_reg));

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign can_load      = !out_valid_reg || result.ready;

    assign mem_ctrl.wr_en = accept && (request.opcode == OPC_WRITE) &&
                            (DIM_W'(request.write_col) < DIM_W'(MAX_WIDTH)) &&
                            (DIM_W'(request.write_row) < DIM_W'(MAX_HEIGHT));
    assign mem_ctrl.rd_en = (state_reg == S_READ);
    assign waddr = AW'(request.write_row) * AW'(MAX_WIDTH) + AW'(request.write_col);

    for (genvar j = 0; j < 4; j++)
    begin : g_addr
        assign raddr[j] = AW'(ys_reg[row_reg]) * AW'(MAX_WIDTH) + AW'(xs_reg[j]);
    end

    crs_pixel_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .waddr (waddr),
        .wdata (request.write_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cub_start = (state_reg == S_START) || (state_reg == S_Y_VAL) ||
                       (state_reg == S_Y_DER);
    assign cub_t     = ((state_reg == S_START) || (state_reg == S_CALC)) ? tx_reg : ty_reg;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (state_reg == S_START)
            begin
                cub_p[j] = ACC_W'(rdata[j]);
            end
            else if (state_reg == S_Y_VAL)
            begin
                cub_p[j] = rv_reg[j];
            end
            else
            begin
                cub_p[j] = rd_reg[j];
            end
        end
    end

    crs_cubic #(
        .FRAC (F)
    ) u_cubic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cub_start),
        .t     (cub_t),
        .p     (cub_p),
        .value (cub_value),
        .deriv (cub_deriv),
        .done  (cub_done)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (request.opcode == OPC_SAMPLE))
                begin
                    state_next = S_READ;
                    row_next   = 2'd0;
                end
            end
            S_READ:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (cub_done)
                begin
                    if (row_reg == 2'd3)
                    begin
                        state_next = S_Y_VAL;
                    end
                    else
                    begin
                        row_next   = row_reg + 2'd1;
                        state_next = S_READ;
                    end
                end
            end
            S_Y_VAL:
            begin
                state_next = S_Y_VAL_WAIT;
            end
            S_Y_VAL_WAIT:
            begin
                if (cub_done)
                begin
                    state_next = S_Y_DER;
                end
            end
            S_Y_DER:
            begin
                state_next = S_Y_DER_WAIT;
            end
            S_Y_DER_WAIT:
            begin
                if (cub_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            width_reg     <= SIZE_RESET;
            height_reg    <= SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_COLS))
            begin
                width_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_ROWS))
            begin
                height_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (request.opcode == OPC_SAMPLE))
        begin
            for (int i = 0; i < 4; i++)
            begin
                xs_reg[i] <= XW'(clamp_idx(request.sample_x, 2'(i), eff_w));
                ys_reg[i] <= YW'(clamp_idx(request.sample_y, 2'(i), eff_h));
            end
            tx_reg <= request.sample_x[F-1:0];
            ty_reg <= request.sample_y[F-1:0];
        end
        if ((state_reg == S_CALC) && cub_done)
        begin
            rv_reg[row_reg] <= cub_value;
            rd_reg[row_reg] <= cub_deriv;
        end
        if ((state_reg == S_Y_VAL_WAIT) && cub_done)
        begin
            val_reg <= cub_value;
            gy_reg  <= cub_deriv;
        end
        if ((state_reg == S_Y_DER_WAIT) && cub_done)
        begin
            gx_reg <= cub_value;
        end
        if ((state_reg == S_OUT) && can_load)
        begin
            out_val_reg <= sat_out(val_reg);
            out_gx_reg  <= sat_out(gx_reg);
            out_gy_reg  <= sat_out(gy_reg);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.sample_value = out_val_reg;
    assign result.grad_x       = out_gx_reg;
    assign result.grad_y       = out_gy_reg;

    a_no_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !cub_done)
        else $error("cubic unit finished with no sample in flight");

    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CALC) && cub_done && (row_reg != 2'd3)) |=>
        ((state_reg == S_READ) && (row_reg == $past(row_reg) + 2'd1)))
        else $error("row sequencing slipped");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

endmodule
